[sv/b64e_pkg.sv]
// Shared types, constants and the Base64 alphabet lookup for the integer Base64 encoder.
// Depends on nothing; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    // Width codes carried by an input request.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_32 = 2'd1;
    localparam logic [1:0] WIDTH_64 = 2'd2;
    localparam logic [1:0] WIDTH_BAD = 2'd3;

    // Byte counts for the legal widths.
    localparam logic [3:0] NBYTES_8  = 4'd1;
    localparam logic [3:0] NBYTES_32 = 4'd4;
    localparam logic [3:0] NBYTES_64 = 4'd8;

    // Bytes consumed by one Base64 group of four characters.
    localparam logic [3:0] GROUP_BYTES = 4'd3;

    // ASCII anchors.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    // Input request payload.
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  width_code;
    } b64e_item_t;

    // Result payload, one character per transfer.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       error;
    } b64e_char_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic        err;
        logic [3:0]  nbytes;
        logic [63:0] value;
    } b64e_cmd_t;

    // Back-end sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } b64e_state_t;

    // Maps a 6-bit index onto the standard Base64 alphabet.
    function automatic logic [7:0] b64e_alpha(input logic [5:0] idx);
        logic [7:0] wide;
        logic [7:0] ch;
        wide = {2'b00, idx};
        case (idx) inside
            [6'd0:6'd25]:  ch = CHAR_UPPER_A + wide;
            [6'd26:6'd51]: ch = CHAR_LOWER_A + wide - 8'd26;
            [6'd52:6'd61]: ch = CHAR_ZERO + wide - 8'd52;
            6'd62:         ch = CHAR_PLUS;
            default:       ch = CHAR_SLASH;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[sv/b64e_stream_if.sv]
// Valid/ready stream interface with a typed payload, used for every channel of the encoder.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none

interface b64e_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/b64e_front.sv]
// Front end: accepts input requests, checks the width code and range, and registers a command.
// Depends on b64e_pkg and b64e_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    b64e_stream_if.sink    item_chan,
    b64e_stream_if.source  cmd_chan
);

    logic      cmd_valid_reg;
    b64e_cmd_t cmd_reg;
    b64e_cmd_t cmd_next;
    logic      take;

    // A new request enters when the command register is empty or draining.
    assign item_chan.ready = !cmd_valid_reg || cmd_chan.ready;
    assign take            = item_chan.valid && item_chan.ready;

    // Classify the request: byte count and the error cases.
    always_comb
    begin
        cmd_next.value  = item_chan.data.value;
        cmd_next.err    = 1'b0;
        cmd_next.nbytes = NBYTES_64;
        case (item_chan.data.width_code)
            WIDTH_8:
            begin
                cmd_next.nbytes = NBYTES_8;
                cmd_next.err    = |item_chan.data.value[63:8];
            end
            WIDTH_32:
            begin
                cmd_next.nbytes = NBYTES_32;
                cmd_next.err    = |item_chan.data.value[63:32];
            end
            WIDTH_64:
            begin
                cmd_next.nbytes = NBYTES_64;
            end
            default:
            begin
                cmd_next.err = 1'b1;
            end
        endcase
    end

    // Command valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_chan.ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_chan.valid = cmd_valid_reg;
    assign cmd_chan.data  = cmd_reg;

endmodule

`default_nettype wire

[sv/b64e_queue.sv]
// Small first-in first-out queue of classified commands between front and back end.
// Depends on b64e_pkg and b64e_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    b64e_stream_if.sink    push_chan,
    b64e_stream_if.source  pop_chan
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_chan.ready = (count_reg != CNT_W'(DEPTH));
    assign pop_chan.valid  = (count_reg != '0);
    assign pop_chan.data   = entry_reg[head_reg];
    assign push            = push_chan.valid && push_chan.ready;
    assign pop             = pop_chan.valid && pop_chan.ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_chan.data;
        end
    end

endmodule

`default_nettype wire

[sv/b64e_back.sv]
// Back end: issues one Base64 character per cycle unless stalled, via a registered output.
// Depends on b64e_pkg and b64e_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    b64e_stream_if.sink    cmd_chan,
    b64e_stream_if.source  char_chan
);

    b64e_state_t state_reg;
    b64e_state_t state_next;
    logic [63:0] work_reg;
    logic [3:0]  left_reg;
    logic        err_reg;
    logic [1:0]  pos_reg;
    logic        out_valid_reg;
    b64e_char_t  out_reg;
    b64e_char_t  out_next;

    logic [23:0] grp;
    logic [5:0]  idx;
    logic [1:0]  avail;
    logic        pad;
    logic        last_char;
    logic        emit;
    logic        pop;

    // Current group with the lowest remaining byte as its most significant byte.
    assign grp = {work_reg[7:0], work_reg[15:8], work_reg[23:16]};

    always_comb
    begin
        case (pos_reg)
            2'd0:    idx = grp[23:18];
            2'd1:    idx = grp[17:12];
            2'd2:    idx = grp[11:6];
            default: idx = grp[5:0];
        endcase
    end

    // Padding and end-of-request detection.
    assign avail     = (left_reg > GROUP_BYTES) ? 2'd3 : left_reg[1:0];
    assign pad       = (pos_reg > avail);
    assign last_char = err_reg || ((pos_reg == 2'd3) && (left_reg <= GROUP_BYTES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_chan.valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && last_char)
                begin
                    state_next = cmd_chan.valid ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: character issue and command pull.
    always_comb
    begin
        emit           = 1'b0;
        cmd_chan.ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_chan.ready = 1'b1;
            end
            ST_RUN:
            begin
                emit           = !out_valid_reg || char_chan.ready;
                cmd_chan.ready = emit && last_char;
            end
            default:
            begin
                emit           = 1'b0;
                cmd_chan.ready = 1'b0;
            end
        endcase
    end

    assign pop = cmd_chan.valid && cmd_chan.ready;

    // Character for the output stage.
    always_comb
    begin
        out_next.last  = last_char;
        out_next.error = err_reg;
        if (err_reg)
        begin
            out_next.out_char = CHAR_NONE;
        end
        else if (pad)
        begin
            out_next.out_char = CHAR_PAD;
        end
        else
        begin
            out_next.out_char = b64e_alpha(idx);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                pos_reg <= 2'd0;
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // Working value, remaining byte count and output payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= cmd_chan.data.value;
            left_reg <= cmd_chan.data.nbytes;
            err_reg  <= cmd_chan.data.err;
        end
        else if (emit && (pos_reg == 2'd3))
        begin
            work_reg <= work_reg >> 24;
            left_reg <= left_reg - GROUP_BYTES;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign char_chan.valid = out_valid_reg;
    assign char_chan.data  = out_reg;

endmodule

`default_nettype wire

[sv/integer_base64_encoder.sv]
// Top level of the integer Base64 encoder: front end, command queue and back end.
// Depends on b64e_pkg, b64e_stream_if, b64e_front, b64e_queue and b64e_back.
//
// Each request carries a 64-bit unsigned value and a width code (8, 32 or 64 bits). The value
// is cut into 1, 4 or 8 bytes, least significant first, and sent out as standard Base64 text
// with '=' padding: 4, 8 or 12 characters, the final one flagged last. A value too wide for
// its code, or the unknown code, gives a single character of zero with error and last set.
// The back end issues one character per cycle while the output is not stalled, and the next
// queued request follows with no gap. The front end classifies each request into a registered
// command, and a QUEUE_DEPTH-entry queue lets it keep accepting while the back end works or
// the output stalls. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_base64_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    b64e_stream_if.sink    item_chan,
    b64e_stream_if.source  char_chan
);

    b64e_stream_if #(.data_t(b64e_cmd_t)) cmd_front ();
    b64e_stream_if #(.data_t(b64e_cmd_t)) cmd_back ();

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_chan (item_chan),
        .cmd_chan  (cmd_front)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_chan (cmd_front),
        .pop_chan  (cmd_back)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_chan  (cmd_back),
        .char_chan (char_chan)
    );

    // An error result is always a single, final character of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_chan.valid && char_chan.data.error |->
            char_chan.data.last && (char_chan.data.out_char == CHAR_NONE))
    else $error("error result without last flag or with nonzero character");

    // The front end never takes a request while its command is refused by the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_chan.ready |-> !(cmd_front.valid && !cmd_front.ready))
    else $error("front end accepted a request while its command was blocked");

    // A popped command puts a character on the output via the back-end and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_back.valid && cmd_back.ready |-> ##2 char_chan.valid)
    else $error("command popped without a character being issued");

endmodule

`default_nettype wire
